// File: rtl/ttsr_pkg.sv
// Shared types, constants and helper functions for the tile text scanline renderer.
package ttsr_pkg;

   localparam int WINDOW_AW        = 12;
   localparam int PIX_W            = 8;
   localparam int COL_W            = 6;
   localparam int LINE_W           = 8;
   localparam int XPOS_W           = 9;
   localparam int CSR_AW           = 5;
   localparam int CSR_DW           = 32;
   localparam int REQ_DATA_W       = 40;
   localparam int RSP_DATA_W       = 24;
   localparam int DEF_TILE_COLUMNS = 40;

   localparam logic [WINDOW_AW-1:0] MAP_BASE = 12'h800;

   localparam logic [PIX_W-1:0] RST_GREEN      = 8'd12;
   localparam logic [PIX_W-1:0] RST_RED        = 8'd3;
   localparam logic [PIX_W-1:0] RST_BLUE       = 8'd48;
   localparam logic [PIX_W-1:0] RST_YELLOW     = 8'd15;
   localparam logic [PIX_W-1:0] RST_CYAN       = 8'd60;
   localparam logic [PIX_W-1:0] RST_MAGENTA    = 8'd51;
   localparam logic [PIX_W-1:0] RST_BACKGROUND = 8'd0;
   localparam logic [PIX_W-1:0] RST_WHITE      = 8'd63;

   // Register indexes double as foreground color codes.
   typedef enum logic [2:0] {
      PAL_GREEN      = 3'd0,
      PAL_RED        = 3'd1,
      PAL_BLUE       = 3'd2,
      PAL_YELLOW     = 3'd3,
      PAL_CYAN       = 3'd4,
      PAL_MAGENTA    = 3'd5,
      PAL_BACKGROUND = 3'd6,
      PAL_WHITE      = 3'd7
   } pal_idx_type;

   typedef enum logic {
      MODE_WRITE  = 1'b0,
      MODE_RENDER = 1'b1
   } mode_type;

   typedef struct packed {
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] yellow;
      logic [PIX_W-1:0] cyan;
      logic [PIX_W-1:0] magenta;
      logic [PIX_W-1:0] background;
      logic [PIX_W-1:0] white;
   } palette_type;

   typedef struct packed {
      mode_type             mode;
      logic [WINDOW_AW-1:0] addr;
      logic [PIX_W-1:0]     wdata;
      logic [2:0]           line;
      logic [COL_W-1:0]     column;
   } a_stage_type;

   typedef struct packed {
      mode_type             mode;
      logic [WINDOW_AW-1:0] addr;
      logic [PIX_W-1:0]     wdata;
      logic [2:0]           line;
      logic [COL_W-1:0]     column;
      logic                 fwd;
      logic [PIX_W-1:0]     fwd_data;
   } b_stage_type;

   typedef struct packed {
      mode_type             mode;
      logic [WINDOW_AW-1:0] addr;
      logic [PIX_W-1:0]     wdata;
      pal_idx_type          fg;
      logic [COL_W-1:0]     column;
   } c_stage_type;

   typedef struct packed {
      pal_idx_type      fg;
      logic [COL_W-1:0] column;
   } d_stage_type;

   typedef struct packed {
      logic [PIX_W-1:0]  pixel;
      logic [XPOS_W-1:0] xpos;
      logic              last;
   } o_stage_type;

   function automatic logic [PIX_W-1:0] pal_pick(input palette_type pal,
                                                 input pal_idx_type idx);
      logic [PIX_W-1:0] val;
      case (idx)
         PAL_GREEN:      val = pal.green;
         PAL_RED:        val = pal.red;
         PAL_BLUE:       val = pal.blue;
         PAL_YELLOW:     val = pal.yellow;
         PAL_CYAN:       val = pal.cyan;
         PAL_MAGENTA:    val = pal.magenta;
         PAL_BACKGROUND: val = pal.background;
         PAL_WHITE:      val = pal.white;
         default:        val = pal.white;
      endcase
      return val;
   endfunction

   // Colored tiles cycle through six entries; everything else is white.
   function automatic pal_idx_type fg_index(input logic [PIX_W-1:0] tile);
      logic [4:0]  rel;
      pal_idx_type idx;
      rel = tile[4:0] - 5'd8;
      if (tile < 8'd8 || tile >= 8'd32) begin
         idx = PAL_WHITE;
      end else begin
         if (rel >= 5'd18) begin
            rel = rel - 5'd18;
         end else if (rel >= 5'd12) begin
            rel = rel - 5'd12;
         end else if (rel >= 5'd6) begin
            rel = rel - 5'd6;
         end
         idx = pal_idx_type'(rel[2:0]);
      end
      return idx;
   endfunction

endpackage

// File: rtl/tile_text_scanline_renderer_core.sv
// Top level of the tile text scanline renderer: pipeline, video memory and palette registers.
//
// Character-mode video generator over a 4 KiB video window. The low 2 KiB hold 8x8 glyphs
// (one byte per glyph row), the tile map starts at byte 2048 with TILE_COLUMNS bytes per
// tile row. A write transaction (req_tuser = 0) stores one byte and yields nothing; a
// render transaction (req_tuser = 1) yields eight pixel transactions, MSB of the glyph row
// first, rsp_tlast on the eighth. The pipeline is: A computes the map address, B holds
// the tile number read from memory, C holds the glyph address and color code, D holds the
// glyph row and shifts out one pixel per cycle into the output register unless the output
// stalls. Writes travel to stage C and update memory as they leave it, so they stay in
// order with renders; a render whose map read overtakes a pending write takes the byte
// from that write directly. Rate: writes are taken every cycle unless a render waits for
// the serializer ahead of them; a render occupies the pixel serializer until its eighth
// pixel moves to the output register, so the next render enters D only then. The memory
// has one write and two read ports.
// Palette writes on the csr_ port take effect on later pixels; write them only when idle.
module tile_text_scanline_renderer_core #(
   parameter int TILE_COLUMNS = ttsr_pkg::DEF_TILE_COLUMNS
) (
   input  logic                            clock,
   input  logic                            reset,
   // slave side
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [11:0] address, [19:12] write_data, [27:20] scanline, [33:28] column, [39:34] zero
   input  logic [ttsr_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] mode
   input  logic                            req_tuser,
   // master side
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] pixel, [16:8] x_position, [23:17] zero
   output logic [ttsr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,
   // configuration
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ttsr_pkg::CSR_AW-1:0]     csr_paddr,
   input  logic [ttsr_pkg::CSR_DW-1:0]     csr_pwdata,
   output logic [ttsr_pkg::CSR_DW-1:0]     csr_prdata,
   output logic                            csr_pready
);
   import ttsr_pkg::*;

   localparam int                   WINDOW_DEPTH = 1 << WINDOW_AW;
   localparam logic [WINDOW_AW-1:0] COLS         = WINDOW_AW'(TILE_COLUMNS);

   // palette registers
   palette_type palette_ff, palette_in;
   logic        csr_wr;

   // video window, undefined until written
   logic [PIX_W-1:0] video_mem [WINDOW_DEPTH];

   // pipeline stages
   logic        a_valid_ff, a_valid_in;
   a_stage_type a_ff, a_in;
   logic        b_valid_ff, b_valid_in;
   b_stage_type b_ff, b_in;
   logic [PIX_W-1:0] b_rd_ff;
   logic        c_valid_ff, c_valid_in;
   c_stage_type c_ff, c_in;
   logic        d_valid_ff, d_valid_in;
   d_stage_type d_ff, d_in;
   logic [PIX_W-1:0] d_glyph_ff;
   logic [2:0]  cnt_ff, cnt_in;
   logic        o_valid_ff, o_valid_in;
   o_stage_type o_ff, o_in;

   logic a_go, b_go, c_go, d_go;
   logic b_ready, c_ready, d_ready, o_ready;
   logic emit;
   logic [PIX_W-1:0]     b_tile;
   logic [WINDOW_AW-1:0] map_addr;
   logic [4:0]           tile_row;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = CSR_DW'(pal_pick(palette_ff, pal_idx_type'(csr_paddr[4:2])));

   always_comb begin
      palette_in = palette_ff;
      if (csr_wr) begin
         case (pal_idx_type'(csr_paddr[4:2]))
            PAL_GREEN:      palette_in.green      = csr_pwdata[PIX_W-1:0];
            PAL_RED:        palette_in.red        = csr_pwdata[PIX_W-1:0];
            PAL_BLUE:       palette_in.blue       = csr_pwdata[PIX_W-1:0];
            PAL_YELLOW:     palette_in.yellow     = csr_pwdata[PIX_W-1:0];
            PAL_CYAN:       palette_in.cyan       = csr_pwdata[PIX_W-1:0];
            PAL_MAGENTA:    palette_in.magenta    = csr_pwdata[PIX_W-1:0];
            PAL_BACKGROUND: palette_in.background = csr_pwdata[PIX_W-1:0];
            PAL_WHITE:      palette_in.white      = csr_pwdata[PIX_W-1:0];
            default:        palette_in = palette_ff;
         endcase
      end
   end

   // ---------------- flow control ----------------
   // Write transactions leave the pipeline from stage C; renders go on to D.
   assign o_ready    = ~o_valid_ff | rsp_tready;
   assign emit       = d_valid_ff & o_ready;
   assign d_go       = emit & (cnt_ff == 3'd7);
   assign d_ready    = ~d_valid_ff | d_go;
   assign c_go       = c_valid_ff & ((c_ff.mode == MODE_WRITE) | d_ready);
   assign c_ready    = ~c_valid_ff | c_go;
   assign b_go       = b_valid_ff & c_ready;
   assign b_ready    = ~b_valid_ff | b_go;
   assign a_go       = a_valid_ff & b_ready;
   assign req_tready = ~a_valid_ff | a_go;

   // ---------------- stage A: map address ----------------
   assign tile_row = req_tdata[27:23];
   assign map_addr = MAP_BASE + WINDOW_AW'({7'd0, tile_row} * COLS)
                   + WINDOW_AW'(req_tdata[33:28]);

   always_comb begin
      a_valid_in = a_valid_ff;
      a_in       = a_ff;
      if (req_tready) begin
         a_valid_in = req_tvalid;
         a_in.mode  = mode_type'(req_tuser);
         a_in.addr  = (req_tuser == MODE_RENDER) ? map_addr : req_tdata[11:0];
         a_in.wdata = req_tdata[19:12];
         a_in.line  = req_tdata[22:20];
         a_in.column = req_tdata[33:28];
      end
   end

   // ---------------- stage B: tile number ----------------
   // Forward from writes still ahead in B or C; the younger one (B) wins.
   always_comb begin
      b_valid_in = b_valid_ff;
      b_in       = b_ff;
      if (b_ready) begin
         b_valid_in  = a_valid_ff;
         b_in.mode   = a_ff.mode;
         b_in.addr   = a_ff.addr;
         b_in.wdata  = a_ff.wdata;
         b_in.line   = a_ff.line;
         b_in.column = a_ff.column;
         b_in.fwd    = 1'b0;
         b_in.fwd_data = c_ff.wdata;
         if (b_valid_ff && b_ff.mode == MODE_WRITE && b_ff.addr == a_ff.addr) begin
            b_in.fwd      = 1'b1;
            b_in.fwd_data = b_ff.wdata;
         end else if (c_valid_ff && c_ff.mode == MODE_WRITE && c_ff.addr == a_ff.addr) begin
            b_in.fwd      = 1'b1;
            b_in.fwd_data = c_ff.wdata;
         end
      end
   end

   assign b_tile = b_ff.fwd ? b_ff.fwd_data : b_rd_ff;

   // ---------------- stage C: glyph address and color ----------------
   always_comb begin
      c_valid_in = c_valid_ff;
      c_in       = c_ff;
      if (c_ready) begin
         c_valid_in  = b_valid_ff;
         c_in.mode   = b_ff.mode;
         c_in.addr   = (b_ff.mode == MODE_RENDER) ? {1'b0, b_tile, b_ff.line} : b_ff.addr;
         c_in.wdata  = b_ff.wdata;
         c_in.fg     = fg_index(b_tile);
         c_in.column = b_ff.column;
      end
   end

   // ---------------- stage D: pixel serializer ----------------
   always_comb begin
      d_valid_in = d_valid_ff;
      d_in       = d_ff;
      cnt_in     = cnt_ff;
      if (emit) begin
         cnt_in = cnt_ff + 3'd1;
      end
      if (d_ready) begin
         d_valid_in = c_valid_ff & (c_ff.mode == MODE_RENDER);
         d_in.fg     = c_ff.fg;
         d_in.column = c_ff.column;
      end
   end

   // ---------------- output register ----------------
   always_comb begin
      o_valid_in = o_valid_ff;
      o_in       = o_ff;
      if (o_ready) begin
         o_valid_in = d_valid_ff;
         o_in.pixel = d_glyph_ff[3'd7 - cnt_ff] ? pal_pick(palette_ff, d_ff.fg)
                                                : palette_ff.background;
         o_in.xpos  = {d_ff.column, cnt_ff};
         o_in.last  = (cnt_ff == 3'd7);
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({o_ff.xpos, o_ff.pixel});
   assign rsp_tlast  = o_ff.last;

   // ---------------- video memory ----------------
   // Map read as a render leaves A, glyph read as it leaves C, write as a write leaves C.
   always_ff @(posedge clock) begin
      if (c_go && c_ff.mode == MODE_WRITE) begin
         video_mem[c_ff.addr] <= c_ff.wdata;
      end
      if (a_go && a_ff.mode == MODE_RENDER) begin
         b_rd_ff <= video_mem[a_ff.addr];
      end
      if (c_go && c_ff.mode == MODE_RENDER) begin
         d_glyph_ff <= video_mem[c_ff.addr];
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         palette_ff <= '{green:      RST_GREEN,
                         red:        RST_RED,
                         blue:       RST_BLUE,
                         yellow:     RST_YELLOW,
                         cyan:       RST_CYAN,
                         magenta:    RST_MAGENTA,
                         background: RST_BACKGROUND,
                         white:      RST_WHITE};
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
         cnt_ff     <= 3'd0;
      end else begin
         palette_ff <= palette_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
         o_valid_ff <= o_valid_in;
         cnt_ff     <= cnt_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      o_ff <= o_in;
   end

endmodule

// File: rtl/ttsr_checker.sv
// Port-level checker for the tile text scanline renderer and its bind statement.
module ttsr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [ttsr_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                            req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ttsr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast,
   input logic                            csr_psel,
   input logic                            csr_penable,
   input logic                            csr_pwrite,
   input logic [ttsr_pkg::CSR_AW-1:0]     csr_paddr,
   input logic [ttsr_pkg::CSR_DW-1:0]     csr_pwdata,
   input logic [ttsr_pkg::CSR_DW-1:0]     csr_prdata,
   input logic                            csr_pready
);

   // last pixel of a cell sits at bit index seven
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[10:8] == 3'd7)
      else $error("tlast on a pixel that is not the eighth of its cell");

   // the rest of a cell follows without a gap, one x step apart
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && rsp_tdata[10:8] == $past(rsp_tdata[10:8]) + 3'd1)
      else $error("pixel run of a cell broken");

   // nothing leaves right after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result shown right after reset");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind tile_text_scanline_renderer_core ttsr_checker u_ttsr_checker (.*);

// File: verif/tile_text_scanline_renderer_core_tb.sv
// Self-checking testbench for the tile text scanline renderer core.
`timescale 1ns / 100ps

module tile_text_scanline_renderer_core_tb;
   import ttsr_pkg::*;

   localparam int TILE_COLUMNS  = DEF_TILE_COLUMNS;
   localparam int WINDOW_BYTES  = 4096;
   localparam int SETTLE_CYCLES = 16;      // pipeline depth plus serializer, with margin
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_ITEMS   = 25;

   // One input transaction, unpacked.
   typedef struct packed {
      mode_type   mode;
      logic [11:0] address;
      logic [7:0]  write_data;
      logic [7:0]  scanline;
      logic [5:0]  column;
   } video_cmd_type;

   // One pixel transaction, unpacked.
   typedef struct packed {
      logic [7:0] pixel;
      logic [8:0] x_position;
      logic       last;
   } pixel_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;

   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [CSR_DW-1:0] csr_pwdata  = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   // Commands waiting for the driver, and pixels the renderer still owes us.
   video_cmd_type  cmd_queue[$];
   pixel_beat_type pixel_queue[$];

   // Generation-time view of the window: which bytes hold data, and what.
   // Renders are only planned once both bytes they read are written.
   logic [7:0] plan_window  [WINDOW_BYTES];
   bit         plan_written [WINDOW_BYTES];

   // Predictor state, updated as transactions are accepted.
   logic [7:0] window_shadow  [WINDOW_BYTES];
   logic [7:0] palette_shadow [8];

   int            send_idle_pct = 0;
   int            stall_pct     = 0;
   int            error_count   = 0;
   int            cycle_count   = 0;
   logic          req_taken     = 1'b0;
   video_cmd_type drive_cmd;

   tile_text_scanline_renderer_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // Foreground entry of a tile: tiles 8..31 rotate through six colors.
   function automatic pal_idx_type tile_color(input logic [7:0] tile);
      pal_idx_type idx;
      if (tile < 8 || tile >= 32) begin
         idx = PAL_WHITE;
      end else begin
         idx = pal_idx_type'(3'((int'(tile) - 8) % 6));
      end
      return idx;
   endfunction

   // Store a byte, or expand one tile cell into eight expected pixels.
   task automatic apply_command(input video_cmd_type cmd);
      int unsigned    map_addr;
      int unsigned    glyph_addr;
      logic [7:0]     tile;
      logic [7:0]     glyph;
      logic [7:0]     ink;
      pixel_beat_type beat;
      if (cmd.mode == MODE_WRITE) begin
         window_shadow[cmd.address] = cmd.write_data;
      end else begin
         map_addr   = (int'(MAP_BASE) + (cmd.scanline / 8) * TILE_COLUMNS + cmd.column)
                      % WINDOW_BYTES;
         tile       = window_shadow[map_addr];
         glyph_addr = (int'(tile) * 8 + cmd.scanline % 8) % WINDOW_BYTES;
         glyph      = window_shadow[glyph_addr];
         ink        = palette_shadow[tile_color(tile)];
         for (int b = 0; b < 8; b++) begin
            beat.pixel      = glyph[7 - b] ? ink : palette_shadow[PAL_BACKGROUND];
            beat.x_position = 9'(int'(cmd.column) * 8 + b);
            beat.last       = (b == 7);
            pixel_queue.push_back(beat);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus planning
   // ------------------------------------------------------------------
   function automatic logic [7:0] pick_tile();
      logic [7:0] tile;
      if ($urandom_range(0, 1) == 0) begin
         tile = 8'($urandom_range(8, 31));
      end else begin
         tile = 8'($urandom_range(0, 255));
      end
      return tile;
   endfunction

   task automatic queue_write(input int unsigned addr, input logic [7:0] data);
      video_cmd_type cmd;
      cmd.mode       = MODE_WRITE;
      cmd.address    = 12'(addr);
      cmd.write_data = data;
      cmd.scanline   = 8'($urandom_range(0, 255));   // ignored on writes
      cmd.column     = 6'($urandom_range(0, 63));
      plan_window[addr]  = data;
      plan_written[addr] = 1'b1;
      cmd_queue.push_back(cmd);
   endtask

   // Queue a render; fill in the map byte and glyph row first if they were never written.
   task automatic queue_render(input logic [7:0] line, input logic [5:0] col);
      int unsigned   map_addr;
      int unsigned   glyph_addr;
      video_cmd_type cmd;
      map_addr = (int'(MAP_BASE) + (line / 8) * TILE_COLUMNS + col) % WINDOW_BYTES;
      if (!plan_written[map_addr]) begin
         queue_write(map_addr, pick_tile());
      end
      glyph_addr = (int'(plan_window[map_addr]) * 8 + line % 8) % WINDOW_BYTES;
      if (!plan_written[glyph_addr]) begin
         queue_write(glyph_addr, 8'($urandom_range(0, 255)));
      end
      cmd.mode       = MODE_RENDER;
      cmd.address    = 12'($urandom_range(0, 4095));  // ignored on renders
      cmd.write_data = 8'($urandom_range(0, 255));
      cmd.scanline   = line;
      cmd.column     = col;
      cmd_queue.push_back(cmd);
   endtask

   // Mostly in-range renders, some off-screen ones, and a mix of writes that
   // reshape the tile map and the glyph table between them.
   task automatic queue_random(input int count);
      int roll;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 45) begin
            queue_render(8'($urandom_range(0, 239)), 6'($urandom_range(0, 39)));
         end else if (roll < 55) begin
            queue_render(8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
         end else if (roll < 70) begin
            queue_write(int'(MAP_BASE) + $urandom_range(0, TILE_COLUMNS * 30 - 1),
                        pick_tile());
         end else if (roll < 85) begin
            queue_write($urandom_range(0, 2047), 8'($urandom_range(0, 255)));
         end else begin
            queue_write($urandom_range(0, 4095), 8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Hold until every command is taken and every pixel is back, then let
   // trailing writes leave the pipeline.
   task automatic drain();
      while (cmd_queue.size() != 0 || req_tvalid || pixel_queue.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write one palette entry, then read it back over the same port.
   task automatic write_palette(input pal_idx_type idx, input logic [7:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {24'h0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[7:0] !== value) begin
         $display("%0t: palette %s read back: expected %0d, got %0d",
                  $time, idx.name(), value, csr_prdata[7:0]);
         error_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      palette_shadow[idx] = value;
   endtask

   // ------------------------------------------------------------------
   // Driver: offer the next command once the current one is taken.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_taken)) begin
         if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            drive_cmd = cmd_queue.pop_front();
            req_tdata <= {6'b0, drive_cmd.column, drive_cmd.scanline,
                          drive_cmd.write_data, drive_cmd.address};
            req_tuser <= drive_cmd.mode;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: drop tready at random according to the current phase.
   always @(negedge clock) begin
      if (!reset) begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Monitor: predict on accepted commands, check accepted pixels.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      video_cmd_type  seen_cmd;
      pixel_beat_type seen_beat;
      pixel_beat_type want_beat;
      req_taken <= req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            seen_cmd.mode       = mode_type'(req_tuser);
            seen_cmd.address    = req_tdata[11:0];
            seen_cmd.write_data = req_tdata[19:12];
            seen_cmd.scanline   = req_tdata[27:20];
            seen_cmd.column     = req_tdata[33:28];
            apply_command(seen_cmd);
         end
         if (rsp_tvalid && rsp_tready) begin
            seen_beat.pixel      = rsp_tdata[7:0];
            seen_beat.x_position = rsp_tdata[16:8];
            seen_beat.last       = rsp_tlast;
            if (pixel_queue.size() == 0) begin
               $display("%0t: unexpected pixel: expected none, got pixel %0d x %0d last %0d",
                        $time, seen_beat.pixel, seen_beat.x_position, seen_beat.last);
               error_count++;
            end else begin
               want_beat = pixel_queue.pop_front();
               if (seen_beat.pixel !== want_beat.pixel
                   || seen_beat.x_position !== want_beat.x_position
                   || seen_beat.last !== want_beat.last) begin
                  $display("%0t: pixel mismatch: expected pixel %0d x %0d last %0d, %s",
                           $time, want_beat.pixel, want_beat.x_position, want_beat.last,
                           $sformatf("got pixel %0d x %0d last %0d", seen_beat.pixel,
                                     seen_beat.x_position, seen_beat.last));
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      palette_shadow[PAL_GREEN]      = RST_GREEN;
      palette_shadow[PAL_RED]        = RST_RED;
      palette_shadow[PAL_BLUE]       = RST_BLUE;
      palette_shadow[PAL_YELLOW]     = RST_YELLOW;
      palette_shadow[PAL_CYAN]       = RST_CYAN;
      palette_shadow[PAL_MAGENTA]    = RST_MAGENTA;
      palette_shadow[PAL_BACKGROUND] = RST_BACKGROUND;
      palette_shadow[PAL_WHITE]      = RST_WHITE;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed cells on the reset palette, no idling.
      queue_write(0, 8'h80);                          // glyph 0, MSB only
      queue_write(int'(MAP_BASE) + 1, 8'd0);          // tile 0 is white
      queue_render(8'd0, 6'd1);
      queue_write(7 * 8 + 3, 8'h01);                  // LSB only
      queue_write(int'(MAP_BASE) + 2, 8'd7);          // last white tile below the colors
      queue_render(8'd3, 6'd2);
      queue_write(8 * 8, 8'hA5);
      queue_write(int'(MAP_BASE), 8'd8);              // first colored tile
      queue_render(8'd0, 6'd0);
      queue_write(31 * 8 + 7, 8'hFF);
      queue_write(int'(MAP_BASE) + 39, 8'd31);        // last colored tile, right edge
      queue_render(8'd7, 6'd39);
      queue_write(255 * 8 + 7, 8'h81);                // top of the glyph table
      queue_write(int'(MAP_BASE) + 29 * TILE_COLUMNS + 39, 8'd255);
      queue_render(8'd239, 6'd39);                    // bottom right cell
      queue_write(32 * 8 + 7, 8'h00);
      queue_write(int'(MAP_BASE) + 31 * TILE_COLUMNS + 63, 8'd32);
      queue_render(8'd255, 6'd63);                    // off screen in both directions
      queue_write(13 * 8 + 3, 8'h5A);
      queue_write(int'(MAP_BASE) + 2, 8'd13);         // rewrite a map byte, then
      queue_render(8'd3, 6'd2);                       // render it right behind the write
      queue_write(4095, 8'hFF);
      queue_render(8'd3, 6'd2);
      queue_random(PHASE_ITEMS);
      drain();

      // Random palette, sender idling.
      for (int i = 0; i < 8; i++) begin
         write_palette(pal_idx_type'(i), 8'($urandom_range(0, 255)));
      end
      send_idle_pct = 63;
      queue_random(PHASE_ITEMS);
      drain();

      // Foreground at maximum, background at minimum; receiver stalling.
      for (int i = 0; i < 8; i++) begin
         write_palette(pal_idx_type'(i),
                       (pal_idx_type'(i) == PAL_BACKGROUND) ? 8'h00 : 8'hFF);
      end
      send_idle_pct = 0;
      stall_pct     = 63;
      queue_random(PHASE_ITEMS);
      drain();

      // The inverse extremes; light idling on both sides.
      for (int i = 0; i < 8; i++) begin
         write_palette(pal_idx_type'(i),
                       (pal_idx_type'(i) == PAL_BACKGROUND) ? 8'hFF : 8'h00);
      end
      send_idle_pct = 11;
      stall_pct     = 11;
      queue_random(PHASE_ITEMS);
      drain();

      // Fresh random palette, full rate again.
      for (int i = 0; i < 8; i++) begin
         write_palette(pal_idx_type'(i), 8'($urandom_range(0, 255)));
      end
      send_idle_pct = 0;
      stall_pct     = 0;
      queue_random(PHASE_ITEMS);
      drain();

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/ttsr_pkg.sv
rtl/tile_text_scanline_renderer_core.sv
rtl/ttsr_checker.sv
verif/tile_text_scanline_renderer_core_tb.sv
